// ===== src/sctl_pkg.sv =====
package sctl_pkg;

   // Field widths of the request and response beats.
   localparam int SECTOR_W = 32;
   localparam int TAG_W    = 30;
   localparam int QTR_W    = 2;
   localparam int SLOT_W   = 3;

   // Status and result from the scan unit to the top level.
   typedef struct packed {
      logic              busy;
      logic              done;
      logic              hit;
      logic              evicted;
      logic [SLOT_W-1:0] slot;
   } scan_status_type;

endpackage

// ===== src/sctl_tag_ram.sv =====
module sctl_tag_ram #(
   parameter int ENTRIES = 8,
   parameter int IDX_W   = 3
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [sctl_pkg::TAG_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [sctl_pkg::TAG_W-1:0] wr_data
);
   import sctl_pkg::*;

   logic [TAG_W-1:0] mem [ENTRIES];
   logic [TAG_W-1:0] rd_data_ff;

   // One write port; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sctl_scan_unit.sv =====
module sctl_scan_unit #(
   parameter int ENTRIES = 8,
   parameter int IDX_W   = 3,
   parameter int CNT_W   = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sctl_pkg::TAG_W-1:0]    tag,
   input  logic                          out_free,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [sctl_pkg::TAG_W-1:0]    rd_data,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output sctl_pkg::scan_status_type     status
);
   import sctl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               match;
   logic               empty;
   logic               done;
   logic [IDX_W-1:0]   victim;
   logic [IDX_W-1:0]   chosen;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   // Shared compare unit: one stored tag against the request per cycle.
   assign match = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data == tag);
   assign empty = cmp_vld_ff && !valid_ff[cmp_idx_ff];

   // Lowest free slot wins a miss; a full table falls back to slot zero.
   assign victim    = free_ff ? free_idx_ff : '0;
   assign chosen    = found_ff ? hit_idx_ff : victim;
   assign slot_wide = {{SLOT_W{1'b0}}, chosen};

   assign rd_en   = (state_ff == S_SCAN) && (rd_cnt_ff < CNT_W'(ENTRIES));
   assign rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign wr_addr = victim;

   // Sequencer next state and bookkeeping.
   always_comb begin
      state_in    = state_ff;
      rd_cnt_in   = rd_cnt_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      wr_en       = 1'b0;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = S_SCAN;
               rd_cnt_in = '0;
               found_in  = 1'b0;
               free_in   = 1'b0;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_addr;
            end
            if (match && !found_ff) begin
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (empty && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
               if (!found_ff) begin
                  wr_en            = 1'b1;
                  valid_in[victim] = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status.busy    = (state_ff != S_IDLE);
   assign status.done    = done;
   assign status.hit     = found_ff;
   assign status.evicted = !found_ff && !free_ff;
   assign status.slot    = slot_wide[SLOT_W-1:0];

   // Control state, valid bits included, clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
      end
   end

   // Scan bookkeeping registers.
   always_ff @(posedge clock) begin
      rd_cnt_ff   <= rd_cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

endmodule

// ===== src/sector_cache_tag_lookup_unit.sv =====
// Tag lookup for a fully associative cache of device sectors.
// A request beat carries a small-sector number on req_virtual_sector; four
// small sectors make one device sector. The unit splits it into a device
// sector and a quarter offset, then walks the tag table one entry per cycle
// through a single comparator fed by the registered read port of the tag memory.
// One response beat follows each request: rsp_hit, the slot that holds or
// now holds the device sector, the device sector, the quarter offset, and
// rsp_evicted when a miss on a full table overwrote slot zero.
// After acceptance the unit reads each entry of the tag memory in turn and
// makes the last compare; the done state then registers the response and,
// on a miss, writes the tag. After each walk the unit returns to idle and
// takes a new request only there, never before it is done with the last.
// Only one request is in flight; req_stall holds until its response loads.
// The response sits in an output register, so a new request is accepted
// while a finished response still waits. If rsp_stall holds the response,
// the next lookup finishes its walk and waits before updating the table.
// Synchronous reset clears all valid bits at once; no clearing pass runs.
module sector_cache_tag_lookup_unit #(
   parameter int ENTRIES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sctl_pkg::SECTOR_W-1:0] req_virtual_sector,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [sctl_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [sctl_pkg::TAG_W-1:0]    rsp_device_sector,
   output logic [sctl_pkg::QTR_W-1:0]    rsp_quarter_offset,
   output logic                          rsp_evicted
);
   import sctl_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic               accept;
   logic               out_free;
   logic [TAG_W-1:0]   tag_ff;
   logic [QTR_W-1:0]   qtr_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [TAG_W-1:0]   rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   scan_status_type    status;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [TAG_W-1:0]   rsp_sector_ff;
   logic [QTR_W-1:0]   rsp_qtr_ff;
   logic               rsp_evicted_ff;

   assign req_stall = status.busy;
   assign accept    = req_valid && !status.busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Capture the request split into device sector and quarter.
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= req_virtual_sector[SECTOR_W-1:QTR_W];
         qtr_ff <= req_virtual_sector[QTR_W-1:0];
      end
   end

   sctl_tag_ram #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tag_ff)
   );

   sctl_scan_unit #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .tag      (tag_ff),
      .out_free (out_free),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .status   (status)
   );

   // Response beat valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, loaded only when the register is free.
   always_ff @(posedge clock) begin
      if (status.done) begin
         rsp_hit_ff     <= status.hit;
         rsp_slot_ff    <= status.slot;
         rsp_sector_ff  <= tag_ff;
         rsp_qtr_ff     <= qtr_ff;
         rsp_evicted_ff <= status.evicted;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_device_sector  = rsp_sector_ff;
   assign rsp_quarter_offset = rsp_qtr_ff;
   assign rsp_evicted        = rsp_evicted_ff;

endmodule

// ===== tb/sv/sector_cache_tag_lookup_unit_chk.sv =====
// Watches both channels of the tag lookup unit, keeps its own copy of the tag
// table, and compares every response beat with the lookup predicted for the
// oldest outstanding request.
module sector_cache_tag_lookup_unit_chk #(
   parameter int ENTRIES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [sctl_pkg::SECTOR_W-1:0] req_virtual_sector,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic [sctl_pkg::SLOT_W-1:0]   rsp_slot,
   input  logic [sctl_pkg::TAG_W-1:0]    rsp_device_sector,
   input  logic [sctl_pkg::QTR_W-1:0]    rsp_quarter_offset,
   input  logic                          rsp_evicted,
   output int                            error_count,
   output int                            pending_count
);
   import sctl_pkg::*;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  device_sector;
      logic [QTR_W-1:0]  quarter_offset;
      logic              evicted;
   } lookup_result_type;

   // Shadow copy of the tag table and the lookups still owed by the unit.
   logic [TAG_W-1:0]  shadow_tags [ENTRIES];
   logic              shadow_valid [ENTRIES];
   lookup_result_type owed_lookups [$];

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   // Look up one request in the shadow table and update it on a miss.
   // The lowest valid matching slot wins; a miss takes the lowest free slot,
   // or slot zero when the table is full.
   function automatic lookup_result_type predict_lookup(
      input logic [SECTOR_W-1:0] sector);
      lookup_result_type result;
      int match;
      int victim;
      int i;
      result.device_sector = sector[SECTOR_W-1:QTR_W];
      result.quarter_offset = sector[QTR_W-1:0];
      result.hit = 1'b0;
      result.evicted = 1'b0;
      match = -1;
      for (i = ENTRIES - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_tags[i] == result.device_sector) begin
            match = i;
         end
      end
      if (match >= 0) begin
         result.hit = 1'b1;
         result.slot = SLOT_W'(match);
      end else begin
         victim = 0;
         for (i = ENTRIES - 1; i >= 0; i--) begin
            if (!shadow_valid[i]) begin
               victim = i;
            end
         end
         result.evicted = shadow_valid[victim];
         shadow_tags[victim] = result.device_sector;
         shadow_valid[victim] = 1'b1;
         result.slot = SLOT_W'(victim);
      end
      return result;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] exp_value,
                                input logic [31:0] got_value);
      if (exp_value !== got_value) begin
         $display("%0t: rsp_%s mismatch, expected %0h, actual %0h",
                  $time, field, exp_value, got_value);
         error_count++;
      end
   endtask

   // Responses are matched before new requests are predicted; a response can
   // never belong to a request accepted at the same edge.
   always @(posedge clock) begin
      lookup_result_type owed;
      if (reset) begin
         foreach (shadow_valid[i]) begin
            shadow_valid[i] = 1'b0;
            shadow_tags[i] = '0;
         end
         owed_lookups.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_lookups.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual hit %0b",
                        $time, rsp_hit, " slot %0d device_sector %0h", rsp_slot,
                        rsp_device_sector, " quarter %0d evicted %0b",
                        rsp_quarter_offset, rsp_evicted);
               error_count++;
            end else begin
               owed = owed_lookups.pop_front();
               compare_field("hit", 32'(owed.hit), 32'(rsp_hit));
               compare_field("slot", 32'(owed.slot), 32'(rsp_slot));
               compare_field("device_sector", 32'(owed.device_sector),
                             32'(rsp_device_sector));
               compare_field("quarter_offset", 32'(owed.quarter_offset),
                             32'(rsp_quarter_offset));
               compare_field("evicted", 32'(owed.evicted), 32'(rsp_evicted));
            end
         end
         if (req_valid && !req_stall) begin
            owed_lookups.push_back(predict_lookup(req_virtual_sector));
         end
      end
      pending_count <= owed_lookups.size();
   end

endmodule

// ===== tb/sv/sector_cache_tag_lookup_unit_tb.sv =====
// Drives request beats into the tag lookup unit, stalls the response side at
// random, and reports the verdict from the checker's error count.
module sector_cache_tag_lookup_unit_tb;
   import sctl_pkg::*;

   localparam int ITEM_COUNT = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 16;

   // Directed opening: quarters of one device sector, the extremes of the
   // request, filling all eight slots, then misses and hits on a full table.
   localparam int DIRECTED_COUNT = 21;
   localparam logic [SECTOR_W-1:0] DIRECTED_SECTORS [DIRECTED_COUNT] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h8000_0000, 32'h0000_0004,
      32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0010,
      32'h7FFF_FFFB, 32'h7FFF_FFF8, 32'h0000_0008, 32'h0000_0000,
      32'h0000_000B, 32'hFFFF_FFFE, 32'h5555_5554, 32'h0000_0013,
      32'h8000_0003
   };

   // Sectors that stay in slots one to seven once the table is full.
   localparam logic [SECTOR_W-1:0] RESIDENT_SECTORS [7] = '{
      32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0004, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0010
   };

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HOLD} stall_mode_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SECTOR_W-1:0] req_virtual_sector;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [TAG_W-1:0]    rsp_device_sector;
   logic [QTR_W-1:0]    rsp_quarter_offset;
   logic                rsp_evicted;
   int                  error_count;
   int                  pending_count;
   int unsigned         cycle_count = 0;
   stall_mode_type      stall_mode = STALL_NONE;
   int                  stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sector_cache_tag_lookup_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_virtual_sector (req_virtual_sector),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_slot           (rsp_slot),
      .rsp_device_sector  (rsp_device_sector),
      .rsp_quarter_offset (rsp_quarter_offset),
      .rsp_evicted        (rsp_evicted)
   );

   sector_cache_tag_lookup_unit_chk checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_virtual_sector (req_virtual_sector),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_slot           (rsp_slot),
      .rsp_device_sector  (rsp_device_sector),
      .rsp_quarter_offset (rsp_quarter_offset),
      .rsp_evicted        (rsp_evicted),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sector_cache_tag_lookup_unit verification failed");
         $finish;
      end
   end

   // Response side back-pressure: free-running stretches, scattered stalls
   // and long holds, each lasting a random number of cycles.
   always @(negedge clock) begin
      int unsigned pick;
      if (stall_left <= 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            stall_mode = STALL_NONE;
            stall_left = $urandom_range(10, 150);
         end else if (pick < 90) begin
            stall_mode = STALL_RANDOM;
            stall_left = $urandom_range(5, 40);
         end else begin
            stall_mode = STALL_HOLD;
            stall_left = $urandom_range(15, 60);
         end
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   // Idle cycles before the next request beat: mostly none or a few, now
   // and then a long pause.
   function automatic int next_gap();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return 0;
      end else if (pick < 9) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 50);
   endfunction

   // Present one request beat after the given idle gap and hold it until the
   // unit takes it. The payload is scrambled while valid is low.
   task automatic send_sector(input logic [SECTOR_W-1:0] sector, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_virtual_sector <= $urandom;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_virtual_sector <= sector;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      int unsigned pick;
      logic [SECTOR_W-1:0] sector;
      logic [SECTOR_W-1:0] last_sector;
      reset = 1'b1;
      req_valid = 1'b0;
      req_virtual_sector = '0;
      last_sector = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SECTORS[i]) begin
         send_sector(DIRECTED_SECTORS[i], next_gap());
         last_sector = DIRECTED_SECTORS[i];
      end

      // Random part: hits on the resident slots, repeats of the last sector
      // (a hit in slot zero after a miss), near misses one tag bit away from
      // a resident sector, and fully random sectors.
      for (int n = 0; n < ITEM_COUNT - DIRECTED_COUNT; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            sector = RESIDENT_SECTORS[$urandom_range(0, 6)];
            sector[QTR_W-1:0] = QTR_W'($urandom);
         end else if (pick < 55) begin
            sector = last_sector;
            sector[QTR_W-1:0] = QTR_W'($urandom);
         end else if (pick < 65) begin
            sector = RESIDENT_SECTORS[$urandom_range(0, 6)]
                     ^ (32'h4 << $urandom_range(0, TAG_W - 1));
         end else begin
            sector = $urandom;
         end
         send_sector(sector, next_gap());
         last_sector = sector;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the outstanding lookups, then allow a few quiet cycles.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sector_cache_tag_lookup_unit verification clean");
      end else begin
         $display("sector_cache_tag_lookup_unit verification failed");
      end
      $finish;
   end

endmodule
